FILE: hw/rtl/ked_pkg.sv
package ked_pkg;

	localparam int KEY_BITS = 10;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int EV_W     = 3;
	localparam int TALLY_W  = 2;
	localparam int CODES_W  = KEY_BITS * EV_W;

	localparam logic [TALLY_W-1:0] DOUBLE_COUNT = TALLY_W'(2);

	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = CFG_W'(1000);
	localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = CFG_W'(300);

	typedef enum logic [0:0] {
		CFG_LONG_PRESS   = 1'b0,
		CFG_DOUBLE_CLICK = 1'b1
	} cfg_idx_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_LONG    = 3'd3,
		EV_DOUBLE  = 3'd4
	} ev_code_t;

	typedef struct packed {
		logic     pressed;
		logic     long_hit;
		ev_code_t code;
	} lane_res_t;

endpackage

FILE: hw/rtl/ked_scan_if.sv
interface ked_scan_if;
	logic                        valid;
	logic                        ready;
	logic [ked_pkg::KEY_BITS-1:0] pin_levels;
	logic [ked_pkg::TIME_W-1:0]   now_ms;
	logic [ked_pkg::KEY_BITS-1:0] clear_mask;

	modport source (output valid, output pin_levels, output now_ms, output clear_mask,
		input ready);
	modport sink (input valid, input pin_levels, input now_ms, input clear_mask,
		output ready);
endinterface

FILE: hw/rtl/ked_result_if.sv
interface ked_result_if;
	logic                        valid;
	logic                        ready;
	logic [ked_pkg::KEY_BITS-1:0] pressed_mask;
	logic [ked_pkg::KEY_BITS-1:0] long_mask;
	logic [ked_pkg::CODES_W-1:0]  event_codes;

	modport source (output valid, output pressed_mask, output long_mask, output event_codes,
		input ready);
	modport sink (input valid, input pressed_mask, input long_mask, input event_codes,
		output ready);
endinterface

FILE: hw/rtl/ked_lane.sv
module ked_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       pin_level,
	input  logic                       clear,
	input  logic [ked_pkg::TIME_W-1:0] now_ms,
	input  logic [ked_pkg::CFG_W-1:0]  long_press_ms,
	input  logic [ked_pkg::CFG_W-1:0]  double_click_ms,
	output ked_pkg::lane_res_t         res
);
	import ked_pkg::*;

	logic               last_raw_q, last_raw_d;
	logic               stable_q, stable_d;
	logic [TIME_W-1:0]  press_stamp_q, press_stamp_d;
	logic               long_done_q, long_done_d;
	logic [TALLY_W-1:0] tally_q, tally_d, tally_inc;
	logic [TIME_W-1:0]  last_press_q, last_press_d;
	ev_code_t           latch_q, latch_d;
	logic               raw;
	logic [TIME_W-1:0]  press_gap;
	logic [TIME_W-1:0]  hold_time;

	assign raw       = ~pin_level;
	assign press_gap = now_ms - last_press_q;
	assign tally_inc = tally_q + TALLY_W'(1);

	always_comb begin
		last_raw_d    = raw;
		stable_d      = stable_q;
		press_stamp_d = press_stamp_q;
		long_done_d   = long_done_q;
		tally_d       = tally_q;
		last_press_d  = last_press_q;
		latch_d       = clear ? EV_NONE : latch_q;
		if (raw == last_raw_q) begin
			if (raw != stable_q) begin
				stable_d = raw;
				if (raw) begin
					press_stamp_d = now_ms;
					long_done_d   = 1'b0;
					last_press_d  = now_ms;
					latch_d       = EV_PRESS;
					if (press_gap < TIME_W'(double_click_ms)) begin
						if (tally_inc >= DOUBLE_COUNT) begin
							latch_d = EV_DOUBLE;
							tally_d = '0;
						end else begin
							tally_d = tally_inc;
						end
					end else begin
						tally_d = TALLY_W'(1);
					end
				end else begin
					latch_d = EV_RELEASE;
				end
			end
		end
		hold_time = now_ms - press_stamp_d;
		// long press is checked only on a scan whose level matched the last one
		if (raw == last_raw_q && stable_d && !long_done_d &&
				hold_time >= TIME_W'(long_press_ms)) begin
			long_done_d = 1'b1;
			latch_d     = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			press_stamp_q <= '0;
			long_done_q   <= 1'b0;
			tally_q       <= '0;
			last_press_q  <= '0;
			latch_q       <= EV_NONE;
		end else if (accept) begin
			last_raw_q    <= last_raw_d;
			stable_q      <= stable_d;
			press_stamp_q <= press_stamp_d;
			long_done_q   <= long_done_d;
			tally_q       <= tally_d;
			last_press_q  <= last_press_d;
			latch_q       <= latch_d;
		end
	end

	assign res.pressed  = stable_d;
	assign res.long_hit = long_done_d;
	assign res.code     = latch_d;
endmodule

FILE: hw/rtl/ked_merge.sv
module ked_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     accept,
	input  ked_pkg::lane_res_t [ked_pkg::KEY_BITS-1:0] lane_res,
	output logic                                     in_ready,
	ked_result_if.source                             result
);
	import ked_pkg::*;

	logic [KEY_BITS-1:0] new_pressed, new_long;
	logic [CODES_W-1:0]  new_codes;
	logic [KEY_BITS-1:0] out_pressed_q, out_long_q, skid_pressed_q, skid_long_q;
	logic [CODES_W-1:0]  out_codes_q, skid_codes_q;
	logic                out_v_q, skid_v_q;
	logic                pop;

	always_comb begin
		for (int k = 0; k < KEY_BITS; k++) begin
			new_pressed[k]          = lane_res[k].pressed;
			new_long[k]             = lane_res[k].long_hit;
			new_codes[k*EV_W +: EV_W] = lane_res[k].code;
		end
	end

	assign in_ready = !skid_v_q;
	assign pop      = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q  <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_pressed_q <= skid_pressed_q;
				out_long_q    <= skid_long_q;
				out_codes_q   <= skid_codes_q;
			end else if (accept) begin
				out_pressed_q <= new_pressed;
				out_long_q    <= new_long;
				out_codes_q   <= new_codes;
			end
		end else if (accept) begin
			// output stalled: park the item in the skid stage
			skid_pressed_q <= new_pressed;
			skid_long_q    <= new_long;
			skid_codes_q   <= new_codes;
		end
	end

	assign result.valid        = out_v_q;
	assign result.pressed_mask = out_pressed_q;
	assign result.long_mask    = out_long_q;
	assign result.event_codes  = out_codes_q;
endmodule

FILE: hw/rtl/key_event_detector_top.sv
// channel  | dir | fields                                  | accept
// scan     | in  | pin_levels, now_ms, clear_mask          | valid && ready
// result   | out | pressed_mask, long_mask, event_codes    | valid && ready
// cfg      | in  | cfg_we, cfg_index, cfg_data (no reply)  | cfg_we
// One scan item a cycle while ready is high: every key has its own lane, all
// lanes update in the cycle the item is taken, and the result is registered.
// A two-entry output stage (register plus skid) lets one more item in while
// a result is stalled; ready drops only when both entries are full.
// Reset: all key state, latches and valid flags clear at once; thresholds
// return to 1000 ms and 300 ms. No clearing pass.
module key_event_detector_top #(
	parameter int NUM_KEYS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ked_scan_if.sink                  scan,
	ked_result_if.source              result,
	input  logic                      cfg_we,
	input  ked_pkg::cfg_idx_t         cfg_index,
	input  logic [ked_pkg::CFG_W-1:0] cfg_data
);
	import ked_pkg::*;

	logic [CFG_W-1:0] long_press_q, double_click_q;
	logic             accept;
	logic             in_ready;
	lane_res_t [KEY_BITS-1:0] lane_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			double_click_q <= DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LONG_PRESS:   long_press_q   <= cfg_data;
				CFG_DOUBLE_CLICK: double_click_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign scan.ready = in_ready;
	assign accept     = scan.valid && in_ready;

	for (genvar k = 0; k < KEY_BITS; k++) begin : g_lane
		if (k < NUM_KEYS) begin : g_on
			ked_lane u_lane (
				.clk             (clk),
				.arst_n          (arst_n),
				.accept          (accept),
				.pin_level       (scan.pin_levels[k]),
				.clear           (scan.clear_mask[k]),
				.now_ms          (scan.now_ms),
				.long_press_ms   (long_press_q),
				.double_click_ms (double_click_q),
				.res             (lane_res[k])
			);
		end else begin : g_off
			assign lane_res[k] = '0;
		end
	end

	ked_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.lane_res (lane_res),
		.in_ready (in_ready),
		.result   (result)
	);
endmodule

FILE: hw/rtl/ked_checker.sv
module ked_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ked_pkg::KEY_BITS-1:0] pressed_mask,
	input logic [ked_pkg::KEY_BITS-1:0] long_mask,
	input logic [ked_pkg::CODES_W-1:0]  event_codes
);
	import ked_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(pressed_mask) && $stable(long_mask) && $stable(event_codes))
		else $error("stalled result changed");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({pressed_mask, long_mask, event_codes}))
		else $error("result fields unknown while valid");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an accepted item");
endmodule

bind key_event_detector_top ked_checker u_ked_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (scan.valid),
	.in_ready     (scan.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.pressed_mask (result.pressed_mask),
	.long_mask    (result.long_mask),
	.event_codes  (result.event_codes)
);
